@@ src/miu_pkg.sv @@
// shared types and constants for the modular inverse unit
package miu_pkg;

    localparam int DataW = 32;
    localparam int CoefW = DataW + 2;
    localparam int CntW  = $clog2(DataW);

    typedef struct packed {
        logic signed [DataW-1:0] a_value;
        logic signed [DataW-1:0] modulus;
    } t_req;

    typedef struct packed {
        logic signed [DataW-1:0] inverse;
    } t_rsp;

    typedef enum logic [1:0] {
        DIV_REDUCE,
        DIV_STEP,
        DIV_FINAL
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     red_store;
        logic     raw_store;
        logic     mul;
        logic     upd;
        logic     fin_raw;
        logic     fin_store;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic rem_zero;
        logic mag_zero;
        logic div_done;
    } t_status;

endpackage

@@ src/miu_stream_if.sv @@
// valid/ready stream channel carrying one payload
interface miu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/miu_div.sv @@
// radix-2 restoring unsigned divider, one quotient bit per cycle
module miu_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [miu_pkg::DataW-1:0]  i_dividend,
    input  logic [miu_pkg::DataW-1:0]  i_divisor,
    output logic                       o_done,
    output logic [miu_pkg::DataW-1:0]  o_quotient,
    output logic [miu_pkg::DataW-1:0]  o_remainder
);
    localparam int W = miu_pkg::DataW;

    logic                      r_busy;
    logic                      r_done;
    logic [miu_pkg::CntW-1:0]  r_cnt;
    logic [W-1:0]              r_quo;
    logic [W-1:0]              r_rem;
    logic [W-1:0]              r_div;

    logic [W:0] shifted;
    logic [W:0] trial;
    logic       fits;

    // bring the next dividend bit into the partial remainder
    assign shifted = {r_rem, r_quo[W-1]};
    assign trial   = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == miu_pkg::CntW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], fits};
            r_rem <= fits ? trial[W-1:0] : shifted[W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && r_busy))
        else $error("divider restarted while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_div != '0) |-> (o_remainder < r_div))
        else $error("divider remainder not below divisor");
endmodule

@@ src/miu_datapath.sv @@
// operand registers, divider, coefficient update and result registers
module miu_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  miu_pkg::t_cmd                     i_cmd,
    input  miu_pkg::t_req                     i_req_data,
    output miu_pkg::t_status                  o_status,
    output logic signed [miu_pkg::DataW-1:0]  o_inverse
);
    localparam int W  = miu_pkg::DataW;
    localparam int CW = miu_pkg::CoefW;

    logic signed [W-1:0]  r_a;
    logic [W-1:0]         r_mag;
    logic [W-1:0]         r_rem_prev;
    logic [W-1:0]         r_rem;
    logic signed [CW-1:0] r_coef_prev;
    logic signed [CW-1:0] r_coef;
    logic signed [CW-1:0] r_prod;
    logic [W-1:0]         r_fin;
    logic [W-1:0]         r_out;

    logic [W-1:0]         a_abs;
    logic [W-1:0]         n_abs;
    logic [CW-1:0]        coef_abs;
    logic [W-1:0]         div_dividend;
    logic [W-1:0]         div_divisor;
    logic                 div_done;
    logic [W-1:0]         div_quo;
    logic [W-1:0]         div_rem;
    logic                 red_neg;
    logic [W-1:0]         red_fix;

    assign a_abs    = r_a[W-1] ? W'(-r_a) : W'(r_a);
    assign n_abs    = i_req_data.modulus[W-1] ? W'(-i_req_data.modulus)
                                              : W'(i_req_data.modulus);
    assign coef_abs = r_coef_prev[CW-1] ? CW'(-r_coef_prev) : CW'(r_coef_prev);

    always_comb begin
        case (i_cmd.div_sel)
            miu_pkg::DIV_REDUCE: begin
                div_dividend = a_abs;
                div_divisor  = r_mag;
                red_neg      = r_a[W-1];
            end
            miu_pkg::DIV_STEP: begin
                div_dividend = r_rem_prev;
                div_divisor  = r_rem;
                red_neg      = 1'b0;
            end
            miu_pkg::DIV_FINAL: begin
                div_dividend = coef_abs[W-1:0];
                div_divisor  = r_mag;
                red_neg      = r_coef_prev[CW-1];
            end
            default: begin
                div_dividend = '0;
                div_divisor  = r_mag;
                red_neg      = 1'b0;
            end
        endcase
    end

    miu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // truncating remainder of a negative value folded back into 0..mag-1
    assign red_fix = (red_neg && div_rem != '0) ? (r_mag - div_rem) : div_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a         <= i_req_data.a_value;
            r_mag       <= n_abs;
            r_coef_prev <= '0;
            r_coef      <= CW'(1);
        end
        if (i_cmd.red_store) begin
            r_rem      <= red_fix;
            r_rem_prev <= r_mag;
        end
        if (i_cmd.raw_store) begin
            // zero modulus: a non-positive value skips the loop
            r_rem      <= r_a[W-1] ? '0 : W'(r_a);
            r_rem_prev <= r_mag;
        end
        if (i_cmd.mul) begin
            r_prod <= CW'($signed({1'b0, div_quo}) * r_coef);
        end
        if (i_cmd.upd) begin
            r_coef      <= r_coef_prev - r_prod;
            r_coef_prev <= r_coef;
            r_rem_prev  <= r_rem;
            r_rem       <= div_rem;
        end
        if (i_cmd.fin_raw) begin
            r_fin <= r_coef_prev[W-1:0];
        end
        if (i_cmd.fin_store) begin
            r_fin <= red_fix;
        end
        if (i_cmd.out_load) begin
            r_out <= r_fin;
        end
    end

    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.mag_zero = (r_mag == '0);
    assign o_status.div_done = div_done;
    assign o_inverse         = $signed(r_out);

    a_step_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_start && i_cmd.div_sel == miu_pkg::DIV_STEP)
        |-> (r_rem != '0 && (r_rem_prev == '0 || r_rem < r_rem_prev)))
        else $error("euclid step started on a remainder that does not shrink");

    a_fin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_store |=> (r_fin < r_mag))
        else $error("reduced coefficient out of range");
endmodule

@@ src/miu_ctrl.sv @@
// sequencer for reduction, euclid steps, final reduction and output hand-off
module miu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  miu_pkg::t_status  i_status,
    output miu_pkg::t_cmd     o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_RED_WAIT,
        S_CHECK,
        S_DIV_WAIT,
        S_MUL,
        S_UPD,
        S_FIN,
        S_FIN_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = miu_pkg::DIV_REDUCE;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                if (i_status.mag_zero) begin
                    o_cmd.raw_store = 1'b1;
                    n_state         = S_CHECK;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_RED_WAIT;
                end
            end
            S_RED_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.red_store = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.div_sel = miu_pkg::DIV_STEP;
                if (i_status.rem_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                o_cmd.div_sel = miu_pkg::DIV_STEP;
                if (i_status.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.div_sel = miu_pkg::DIV_STEP;
                o_cmd.mul     = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.div_sel = miu_pkg::DIV_STEP;
                o_cmd.upd     = 1'b1;
                n_state       = S_CHECK;
            end
            S_FIN: begin
                o_cmd.div_sel = miu_pkg::DIV_FINAL;
                if (i_status.mag_zero) begin
                    o_cmd.fin_raw = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_FIN_WAIT;
                end
            end
            S_FIN_WAIT: begin
                o_cmd.div_sel = miu_pkg::DIV_FINAL;
                if (i_status.div_done) begin
                    o_cmd.fin_store = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                // wait until the output register is free or being emptied
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
endmodule

@@ src/modular_inverse_unit.sv @@
// Modular inverse by the extended Euclidean algorithm. A request carries a
// signed value and a signed modulus; the response is the Bezout coefficient
// of the value reduced into 0..|modulus|-1, or the raw coefficient when the
// modulus is zero. There is no flag for a value that is not coprime with the
// modulus. One request is worked at a time on a single shared radix-2
// divider. A request is taken and reduced, then goes through up to about
// 46 Euclid steps (check, division, multiply, update), and ends with the
// last check, the final reduction and the load of the output register. A
// zero modulus with a non-positive value skips the divider entirely.
// The result waits in an output register, so a new request is taken while
// the previous response is still pending.
module modular_inverse_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    miu_stream_if.sink    i_req,
    miu_stream_if.source  o_rsp
);
    miu_pkg::t_cmd    cmd;
    miu_pkg::t_status status;
    logic             req_ready;
    logic             rsp_valid;
    logic signed [miu_pkg::DataW-1:0] inverse;

    miu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    miu_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req_data (i_req.data),
        .o_status   (status),
        .o_inverse  (inverse)
    );

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = rsp_valid;
    assign o_rsp.data.inverse = inverse;
endmodule

@@ tb/testbench.sv @@
// testbench for the modular inverse unit: self-checking random and directed requests
class inverse_scoreboard;
    miu_pkg::t_rsp expected_rsp[$];
    int            errors;

    function new();
        errors = 0;
    endfunction

    // C-style remainder folded into 0..m-1, value untouched for m == 0
    function longint fold(longint v, longint m);
        longint r;
        if (m == 0) return v;
        r = v % m;
        return (r < 0) ? r + m : r;
    endfunction

    function logic signed [31:0] modinv(miu_pkg::t_req r);
        longint mag;
        longint rem_prev;
        longint rem;
        longint coef_prev;
        longint coef;
        longint quo;
        longint nxt;
        mag = $signed(r.modulus);
        if (mag < 0) mag = -mag;
        rem_prev  = mag;
        rem       = fold($signed(r.a_value), mag);
        coef_prev = 0;
        coef      = 1;
        while (rem > 0) begin
            quo       = rem_prev / rem;
            nxt       = rem_prev % rem;
            rem_prev  = rem;
            rem       = nxt;
            nxt       = coef_prev - quo * coef;
            coef_prev = coef;
            coef      = nxt;
        end
        nxt = fold(coef_prev, mag);
        return nxt[31:0];
    endfunction

    function void note_request(miu_pkg::t_req r);
        miu_pkg::t_rsp e;
        e.inverse = modinv(r);
        expected_rsp = {expected_rsp, e};
    endfunction

    function void check_response(miu_pkg::t_rsp got);
        miu_pkg::t_rsp e;
        if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected response: inverse=%0d", got.inverse);
            return;
        end
        e = expected_rsp.pop_front();
        if (got.inverse !== e.inverse) begin
            errors++;
            if (errors <= 10)
                $display("inverse mismatch: expected %0d, got %0d", e.inverse, got.inverse);
        end
    endfunction

    function int pending();
        return expected_rsp.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        K_FULL,
        K_SMALL_MOD,
        K_BIG_ODD_MOD,
        K_FIBONACCI,
        K_SHARED_FACTOR,
        K_DEGENERATE_MOD,
        K_MULTIPLE,
        K_EXTREME
    } t_kind;

    logic clk;
    logic rst_n;

    miu_stream_if #(.T(miu_pkg::t_req)) req_if ();
    miu_stream_if #(.T(miu_pkg::t_rsp)) rsp_if ();

    modular_inverse_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    inverse_scoreboard sb = new();

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int rsp_hold_left = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("[modular_inverse_unit] ERROR");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rsp_hold_left > 0) begin
                rsp_if.ready = 1'b0;
                rsp_hold_left--;
            end else begin
                rsp_if.ready = rst_n && ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.data);
    end

    function automatic miu_pkg::t_req mk_req(logic signed [31:0] a, logic signed [31:0] n);
        miu_pkg::t_req r;
        r.a_value = a;
        r.modulus = n;
        return r;
    endfunction

    function automatic miu_pkg::t_req random_req();
        miu_pkg::t_req       r;
        t_kind               kind;
        int                  pick;
        int                  k;
        logic signed [31:0]  f_prev;
        logic signed [31:0]  f_cur;
        logic signed [31:0]  f_nxt;
        logic signed [31:0]  g;
        logic signed [31:0]  extremes[5];
        extremes = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000};
        pick = $urandom_range(9);
        kind = (pick < 3) ? K_FULL : t_kind'(pick - 2);
        r.a_value = $urandom;
        r.modulus = $urandom;
        case (kind)
            K_SMALL_MOD: begin
                r.modulus = $urandom_range(1000, 1);
            end
            K_BIG_ODD_MOD: begin
                r.modulus = $urandom_range(32'h7fffffff, 32'h40000000) | 1;
            end
            K_FIBONACCI: begin
                // consecutive fibonacci numbers give the longest euclid chains
                k = $urandom_range(46, 20);
                f_prev = 0;
                f_cur  = 1;
                for (int i = 1; i < k; i++) begin
                    f_nxt  = f_prev + f_cur;
                    f_prev = f_cur;
                    f_cur  = f_nxt;
                end
                r.a_value = f_prev;
                r.modulus = f_cur;
                if ($urandom_range(1)) r.a_value = -r.a_value;
            end
            K_SHARED_FACTOR: begin
                g = $urandom_range(1000, 2);
                r.a_value = g * $signed($urandom_range(1000000, 1));
                r.modulus = g * $signed($urandom_range(2000000, 1));
            end
            K_DEGENERATE_MOD: begin
                r.modulus = $urandom_range(1);
            end
            K_MULTIPLE: begin
                r.modulus = $urandom_range(100000, 1);
                r.a_value = r.modulus * $signed($urandom_range(20000, 0));
            end
            K_EXTREME: begin
                r.a_value = extremes[$urandom_range(4)];
                r.modulus = extremes[$urandom_range(3)];
            end
            default: ;
        endcase
        if (kind != K_FULL && $urandom_range(1)) r.modulus = -r.modulus;
        // the most negative modulus is kept to the directed part
        if (r.modulus == 32'sh80000000) r.modulus = 32'sh80000001;
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_req(miu_pkg::t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    initial begin
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_req(mk_req(0, 0));
        send_req(mk_req(5, 0));
        send_req(mk_req(-5, 0));
        send_req(mk_req(32'sh7fffffff, 0));
        send_req(mk_req(32'sh80000000, 0));
        send_req(mk_req(3, 7));
        send_req(mk_req(-3, 7));
        send_req(mk_req(3, -7));
        send_req(mk_req(7, 7));
        send_req(mk_req(-14, 7));
        send_req(mk_req(12345, 1));
        send_req(mk_req(-12345, -1));
        send_req(mk_req(6, 9));
        send_req(mk_req(1, 32'sh7fffffff));
        send_req(mk_req(32'sh7ffffffe, 32'sh7fffffff));
        send_req(mk_req(32'sh80000000, 32'sh7fffffff));
        send_req(mk_req(32'sh80000000, 32'sh80000001));
        send_req(mk_req(3, 32'sh80000000));
        send_req(mk_req(-1, 32'sh80000000));
        send_req(mk_req(32'sh7fffffff, 32'sh80000000));
        send_req(mk_req(1134903170, 1836311903));
        send_req(mk_req(-1134903170, -1836311903));
        send_req(mk_req(32'sh55555555, 32'sh2aaaaaab));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
                default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
            endcase
            for (int i = 0; i < 100; i++) begin
                // long response hold-off while requests keep coming, to back up the input
                if (phase == 0 && i == 40) rsp_hold_left = 5000;
                send_req(random_req());
            end
            // sender pauses until every response is back
            drain();
        end

        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[modular_inverse_unit] OK");
        end else begin
            $display("[modular_inverse_unit] ERROR");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/miu_pkg.sv
src/miu_stream_if.sv
src/miu_div.sv
src/miu_datapath.sv
src/miu_ctrl.sv
src/modular_inverse_unit.sv
tb/testbench.sv
